>>> rtl/btmca_pkg.sv
// shared constants, codes and types of the binary tree min-cost assignment block
package btmca_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int NODE_W    = 11;
  localparam int CAP_W     = 16;
  localparam int FLOW_W    = 18;
  localparam int COST_W    = 8;
  localparam int BEST_W    = COST_W + NODE_W;
  localparam int CHILD_W   = COST_W + 1;
  localparam int UP_W      = $clog2(ADDR_W + 2) + 1;
  localparam int SUM_W     = COST_W + 2;
  localparam int STEP_W    = 6;
  localparam int TOTAL_W   = 32;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  localparam logic [FLOW_W-1:0] FLOW_MAX   = {1'b0, {(FLOW_W-1){1'b1}}};
  localparam logic [FLOW_W-1:0] FLOW_MIN   = {1'b1, {(FLOW_W-1){1'b0}}};
  localparam logic [NODE_W-1:0] NODE_LIMIT = NODE_W'(MAX_NODES);

  // register index, taken from the word address bit of paddr
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_SERVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_BUILD,
    PH_NODE,
    PH_Q
  } phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SRCH_A,
    ST_SRCH_B,
    ST_CAP_A,
    ST_CAP_B,
    ST_UP_A,
    ST_UP_B,
    ST_DN_A,
    ST_DN_B,
    ST_REF_A,
    ST_REF_B,
    ST_REF_C,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/btmca_ram.sv
// generic single write port, single read port ram with registered read
module btmca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/binary_tree_min_cost_assignment.sv
// top level: sequencer, shared compare unit and memories of the tree assignment block
//
//  channel  | ports                                        | transfer
//  ---------+----------------------------------------------+--------------------------------
//  command  | start busy cmd node capacity                 | edge with start high, busy low
//  result   | done step_cost total_cost served_node        | edge ending the cycle done is high
//           | no_capacity                                  |
//  config   | psel penable pwrite paddr pwdata prdata      | edge with psel penable pwrite
//           | pready                                       | pready high
//
// build works through every node in use, a request through each searched level,
// each flow edge and each refreshed node; the single read port of the minima
// memory sets the pace. after reset a clearing pass zeroes the capacity and flow
// memories with busy high. results come in the cycle after the last work cycle
// and cannot be held off; busy drops in that same cycle.
module binary_tree_min_cost_assignment (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [btmca_pkg::NODE_W-1:0]  node,
  input  logic [btmca_pkg::CAP_W-1:0]   capacity,
  output logic                          done,
  output logic [btmca_pkg::STEP_W-1:0]  step_cost,
  output logic [btmca_pkg::TOTAL_W-1:0] total_cost,
  output logic [btmca_pkg::NODE_W-1:0]  served_node,
  output logic                          no_capacity,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btmca_pkg::PADDR_W-1:0] paddr,
  input  logic [btmca_pkg::DATA_W-1:0]  pwdata,
  output logic [btmca_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW  = btmca_pkg::ADDR_W;
  localparam int NW  = btmca_pkg::NODE_W;
  localparam int CW  = btmca_pkg::CAP_W;
  localparam int FW  = btmca_pkg::FLOW_W;
  localparam int KW  = btmca_pkg::COST_W;
  localparam int BW  = btmca_pkg::BEST_W;
  localparam int HW  = btmca_pkg::CHILD_W;
  localparam int UW  = btmca_pkg::UP_W;
  localparam int SW  = btmca_pkg::SUM_W;
  localparam int TW  = btmca_pkg::TOTAL_W;
  localparam int PW  = btmca_pkg::STEP_W;

  localparam logic [NW-1:0]        NODE_ONE  = NW'(1);
  localparam logic signed [HW-1:0] CH_ONE    = HW'(1);
  localparam logic signed [UW-1:0] UP_ONE    = UW'(1);
  localparam logic signed [HW-1:0] CH_HI     = HW'(127);
  localparam logic signed [HW-1:0] CH_LO     = -HW'(128);
  localparam logic signed [SW-1:0] STEP_HI   = SW'(63);
  localparam logic [AW-1:0]        CLR_LAST  = AW'(btmca_pkg::MAX_NODES - 1);

  btmca_pkg::state_t state, state_next;
  btmca_pkg::phase_t phase, phase_next;

  logic [AW-1:0]        clr_cnt, clr_cnt_next;
  logic [NW-1:0]        node_count;
  logic [1:0]           cmd_r, cmd_r_next;
  logic [NW-1:0]        node_r, node_r_next;
  logic [CW-1:0]        cap_r, cap_r_next;
  logic [NW-1:0]        idx, idx_next;
  logic [NW-1:0]        top, top_next;
  logic [NW-1:0]        q, q_next;
  logic signed [UW-1:0] up, up_next;
  logic signed [SW-1:0] best, best_next;
  logic                 cap_nz, cap_nz_next;
  logic                 c0_ok, c0_ok_next;
  logic signed [HW-1:0] c0_cost, c0_cost_next;
  logic [NW-1:0]        c0_node, c0_node_next;
  logic                 res_flag, res_flag_next;
  logic [TW-1:0]        cost_sum, cost_sum_next;

  logic                 done_next;
  logic [PW-1:0]        step_cost_next;
  logic [TW-1:0]        total_cost_next;
  logic [NW-1:0]        served_node_next;
  logic                 no_capacity_next;

  // memory ports
  logic          cap_we, flow_we, best_we;
  logic [AW-1:0] cap_waddr, flow_waddr, best_waddr;
  logic [AW-1:0] cap_raddr, flow_raddr, best_raddr;
  logic [CW-1:0] cap_wdata, cap_rdata;
  logic [FW-1:0] flow_wdata, flow_rdata;
  logic [BW-1:0] best_wdata, best_rdata;

  // configuration
  logic          cfg_wr;
  logic [NW-1:0] cfg_raw, cfg_val;

  // shared compare unit
  logic signed [KW-1:0] rd_cost;
  logic [NW-1:0]        rd_node;
  logic                 flow_pos, flow_neg;
  logic signed [HW-1:0] rd_child_cost, rd_cost_ext;
  logic signed [SW-1:0] srch_cand;
  logic                 srch_take;
  logic [NW-1:0]        top_sel, q_sel;
  logic signed [SW-1:0] best_sel;
  logic                 c0_in_tree, c1_in_tree, c1_ok;
  logic                 pick_have;
  logic signed [HW-1:0] pick_cost;
  logic [NW-1:0]        pick_node;
  logic [KW-1:0]        pick_cost8;
  logic [FW-1:0]        flow_inc, flow_dec;
  logic [PW-1:0]        step_sat, fin_step;
  logic                 fin_served;
  logic [TW:0]          sum_wide;

  // refresh loop advance
  btmca_pkg::state_t adv_state;
  btmca_pkg::phase_t adv_phase;
  logic [NW-1:0]     adv_idx;

  function automatic logic [AW-1:0] node_addr(input logic [NW:0] n);
    logic [NW:0] m;
    m = n - 1'b1;
    return m[AW-1:0];
  endfunction

  btmca_ram #(.WIDTH(CW), .DEPTH(btmca_pkg::MAX_NODES)) u_cap_ram (
    .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
    .raddr(cap_raddr), .rdata(cap_rdata)
  );

  btmca_ram #(.WIDTH(FW), .DEPTH(btmca_pkg::MAX_NODES)) u_flow_ram (
    .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
    .raddr(flow_raddr), .rdata(flow_rdata)
  );

  btmca_ram #(.WIDTH(BW), .DEPTH(btmca_pkg::MAX_NODES)) u_best_ram (
    .clk(clk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
    .raddr(best_raddr), .rdata(best_rdata)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_raw = pwdata[NW-1:0];
  assign cfg_val = (cfg_raw == '0) ? NODE_ONE :
                   (cfg_raw > btmca_pkg::NODE_LIMIT) ? btmca_pkg::NODE_LIMIT : cfg_raw;
  assign prdata  = (paddr[btmca_pkg::PADDR_W-1] == btmca_pkg::REG_NODE_COUNT) ?
                   btmca_pkg::DATA_W'(node_count) : '0;

  assign busy = (state != btmca_pkg::ST_IDLE);

  // decode of the minima and flow read data
  assign rd_cost       = best_rdata[BW-1:NW];
  assign rd_node       = best_rdata[NW-1:0];
  assign flow_neg      = flow_rdata[FW-1];
  assign flow_pos      = !flow_rdata[FW-1] && (flow_rdata != '0);
  assign rd_cost_ext   = $signed({rd_cost[KW-1], rd_cost});
  assign rd_child_cost = flow_pos ? (rd_cost_ext - CH_ONE) : (rd_cost_ext + CH_ONE);

  // search: path cost through the current ancestor
  assign srch_cand = $signed({{(SW-UW){up[UW-1]}}, up}) +
                     $signed({{(SW-KW){rd_cost[KW-1]}}, rd_cost});
  assign srch_take = (rd_node != '0) && ((top == '0) || (best > srch_cand));
  assign top_sel   = srch_take ? idx : top;
  assign q_sel     = srch_take ? rd_node : q;
  assign best_sel  = srch_take ? srch_cand : best;

  // refresh: own capacity, then left child, then right child
  assign c0_in_tree = ({idx, 1'b0} <= {1'b0, node_count});
  assign c1_in_tree = ({idx, 1'b1} <= {1'b0, node_count});
  assign c1_ok      = c1_in_tree && (rd_node != '0);

  always_comb begin
    pick_have = cap_nz;
    pick_cost = '0;
    pick_node = cap_nz ? idx : '0;
    if (c0_ok && (!pick_have || (pick_cost > c0_cost))) begin
      pick_have = 1'b1;
      pick_cost = c0_cost;
      pick_node = c0_node;
    end
    if (c1_ok && (!pick_have || (pick_cost > rd_child_cost))) begin
      pick_have = 1'b1;
      pick_cost = rd_child_cost;
      pick_node = rd_node;
    end
    if (pick_cost > CH_HI) begin
      pick_cost8 = CH_HI[KW-1:0];
    end else if (pick_cost < CH_LO) begin
      pick_cost8 = CH_LO[KW-1:0];
    end else begin
      pick_cost8 = pick_cost[KW-1:0];
    end
  end

  assign flow_inc = (flow_rdata == btmca_pkg::FLOW_MAX) ? flow_rdata : flow_rdata + 1'b1;
  assign flow_dec = (flow_rdata == btmca_pkg::FLOW_MIN) ? flow_rdata : flow_rdata - 1'b1;

  assign step_sat   = (best < 0) ? '0 : (best > STEP_HI) ? STEP_HI[PW-1:0] : best[PW-1:0];
  assign fin_served = (cmd_r == btmca_pkg::CMD_SERVE) && !res_flag;
  assign fin_step   = fin_served ? step_sat : '0;
  assign sum_wide   = {1'b0, cost_sum} + (TW+1)'(fin_step);

  // next node of a refresh walk: build counts down, root paths halve
  always_comb begin
    adv_state = btmca_pkg::ST_REF_A;
    adv_phase = phase;
    adv_idx   = idx;
    unique case (phase)
      btmca_pkg::PH_BUILD: begin
        if (idx <= NODE_ONE) adv_state = btmca_pkg::ST_FINISH;
        else adv_idx = idx - NODE_ONE;
      end
      btmca_pkg::PH_NODE: begin
        if (idx <= NODE_ONE) begin
          adv_idx   = q;
          adv_phase = btmca_pkg::PH_Q;
        end else begin
          adv_idx = idx >> 1;
        end
      end
      btmca_pkg::PH_Q: begin
        if (idx <= NODE_ONE) adv_state = btmca_pkg::ST_FINISH;
        else adv_idx = idx >> 1;
      end
      default: adv_state = btmca_pkg::ST_FINISH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= btmca_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      node_count <= NODE_ONE;
      cost_sum   <= '0;
      done       <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      cost_sum <= cost_sum_next;
      done     <= done_next;
      if (cfg_wr && (paddr[btmca_pkg::PADDR_W-1] == btmca_pkg::REG_NODE_COUNT)) begin
        node_count <= cfg_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase       <= phase_next;
    cmd_r       <= cmd_r_next;
    node_r      <= node_r_next;
    cap_r       <= cap_r_next;
    idx         <= idx_next;
    top         <= top_next;
    q           <= q_next;
    up          <= up_next;
    best        <= best_next;
    cap_nz      <= cap_nz_next;
    c0_ok       <= c0_ok_next;
    c0_cost     <= c0_cost_next;
    c0_node     <= c0_node_next;
    res_flag    <= res_flag_next;
    step_cost   <= step_cost_next;
    total_cost  <= total_cost_next;
    served_node <= served_node_next;
    no_capacity <= no_capacity_next;
  end

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    clr_cnt_next     = clr_cnt;
    cmd_r_next       = cmd_r;
    node_r_next      = node_r;
    cap_r_next       = cap_r;
    idx_next         = idx;
    top_next         = top;
    q_next           = q;
    up_next          = up;
    best_next        = best;
    cap_nz_next      = cap_nz;
    c0_ok_next       = c0_ok;
    c0_cost_next     = c0_cost;
    c0_node_next     = c0_node;
    res_flag_next    = res_flag;
    cost_sum_next    = cost_sum;
    done_next        = 1'b0;
    step_cost_next   = step_cost;
    total_cost_next  = total_cost;
    served_node_next = served_node;
    no_capacity_next = no_capacity;

    cap_we     = 1'b0;
    cap_waddr  = node_addr({1'b0, idx});
    cap_wdata  = '0;
    cap_raddr  = node_addr({1'b0, idx});
    flow_we    = 1'b0;
    flow_waddr = node_addr({1'b0, idx});
    flow_wdata = '0;
    flow_raddr = node_addr({1'b0, idx});
    best_we    = 1'b0;
    best_waddr = node_addr({1'b0, idx});
    best_wdata = {pick_cost8, pick_node};
    best_raddr = node_addr({1'b0, idx});

    unique case (state)
      btmca_pkg::ST_CLEAR: begin
        cap_we       = 1'b1;
        cap_waddr    = clr_cnt;
        flow_we      = 1'b1;
        flow_waddr   = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == CLR_LAST) state_next = btmca_pkg::ST_IDLE;
      end

      btmca_pkg::ST_IDLE: begin
        if (start) begin
          cmd_r_next    = cmd;
          node_r_next   = node;
          cap_r_next    = capacity;
          res_flag_next = 1'b0;
          unique case (cmd)
            btmca_pkg::CMD_LOAD: state_next = btmca_pkg::ST_LOAD;
            btmca_pkg::CMD_BUILD: begin
              idx_next   = node_count;
              phase_next = btmca_pkg::PH_BUILD;
              state_next = btmca_pkg::ST_REF_A;
            end
            btmca_pkg::CMD_SERVE: begin
              if ((node == '0) || (node > node_count)) begin
                res_flag_next = 1'b1;
                state_next    = btmca_pkg::ST_FINISH;
              end else begin
                idx_next   = node;
                top_next   = '0;
                q_next     = '0;
                up_next    = '0;
                best_next  = '0;
                state_next = btmca_pkg::ST_SRCH_A;
              end
            end
            default: state_next = btmca_pkg::ST_FINISH;
          endcase
        end
      end

      btmca_pkg::ST_LOAD: begin
        if ((node_r != '0) && (node_r <= btmca_pkg::NODE_LIMIT)) begin
          cap_we    = 1'b1;
          cap_waddr = node_addr({1'b0, node_r});
          cap_wdata = cap_r;
        end
        state_next = btmca_pkg::ST_FINISH;
      end

      // walk to the root, keeping the cheapest ancestor
      btmca_pkg::ST_SRCH_A: begin
        state_next = btmca_pkg::ST_SRCH_B;
      end

      btmca_pkg::ST_SRCH_B: begin
        top_next  = top_sel;
        q_next    = q_sel;
        best_next = best_sel;
        if (idx > NODE_ONE) begin
          up_next    = flow_neg ? (up - UP_ONE) : (up + UP_ONE);
          idx_next   = idx >> 1;
          state_next = btmca_pkg::ST_SRCH_A;
        end else if (top_sel == '0) begin
          res_flag_next = 1'b1;
          state_next    = btmca_pkg::ST_FINISH;
        end else begin
          if (q_sel > btmca_pkg::NODE_LIMIT) q_next = '0;
          state_next = btmca_pkg::ST_CAP_A;
        end
      end

      btmca_pkg::ST_CAP_A: begin
        cap_raddr = node_addr({1'b0, q});
        if (q == '0) begin
          idx_next   = node_r;
          state_next = btmca_pkg::ST_UP_A;
        end else begin
          state_next = btmca_pkg::ST_CAP_B;
        end
      end

      btmca_pkg::ST_CAP_B: begin
        cap_waddr = node_addr({1'b0, q});
        cap_wdata = cap_rdata - 1'b1;
        cap_we    = (cap_rdata != '0);
        idx_next   = node_r;
        state_next = btmca_pkg::ST_UP_A;
      end

      // origin side of the path gains flow
      btmca_pkg::ST_UP_A: begin
        if (idx > top) begin
          state_next = btmca_pkg::ST_UP_B;
        end else begin
          idx_next   = q;
          state_next = btmca_pkg::ST_DN_A;
        end
      end

      btmca_pkg::ST_UP_B: begin
        flow_we    = 1'b1;
        flow_wdata = flow_inc;
        idx_next   = idx >> 1;
        state_next = btmca_pkg::ST_UP_A;
      end

      // served side of the path loses flow
      btmca_pkg::ST_DN_A: begin
        if (idx > top) begin
          state_next = btmca_pkg::ST_DN_B;
        end else begin
          idx_next   = node_r;
          phase_next = btmca_pkg::PH_NODE;
          state_next = btmca_pkg::ST_REF_A;
        end
      end

      btmca_pkg::ST_DN_B: begin
        flow_we    = 1'b1;
        flow_wdata = flow_dec;
        idx_next   = idx >> 1;
        state_next = btmca_pkg::ST_DN_A;
      end

      btmca_pkg::ST_REF_A: begin
        best_raddr = node_addr({idx, 1'b0});
        flow_raddr = node_addr({idx, 1'b0});
        if ((idx == '0) || (idx > node_count)) begin
          state_next = adv_state;
          phase_next = adv_phase;
          idx_next   = adv_idx;
        end else begin
          state_next = btmca_pkg::ST_REF_B;
        end
      end

      btmca_pkg::ST_REF_B: begin
        cap_nz_next  = (cap_rdata != '0);
        c0_ok_next   = c0_in_tree && (rd_node != '0);
        c0_cost_next = rd_child_cost;
        c0_node_next = rd_node;
        best_raddr   = node_addr({idx, 1'b1});
        flow_raddr   = node_addr({idx, 1'b1});
        state_next   = btmca_pkg::ST_REF_C;
      end

      btmca_pkg::ST_REF_C: begin
        best_we    = 1'b1;
        state_next = adv_state;
        phase_next = adv_phase;
        idx_next   = adv_idx;
      end

      btmca_pkg::ST_FINISH: begin
        cost_sum_next    = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
        done_next        = 1'b1;
        step_cost_next   = fin_step;
        total_cost_next  = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
        served_node_next = fin_served ? q : '0;
        no_capacity_next = res_flag;
        state_next       = btmca_pkg::ST_IDLE;
      end

      default: state_next = btmca_pkg::ST_IDLE;
    endcase
  end

  a_done_when_ready: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is still busy");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not start the sequencer");

  a_flag_clean: assert property (@(posedge clk) disable iff (rst)
    (done && no_capacity) |-> ((step_cost == '0) && (served_node == '0)))
    else $error("failed request reports a cost or a served node");

  a_total_tracks_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (total_cost == cost_sum))
    else $error("reported total differs from the running cost sum");

endmodule

>>> tb/btmca_result_checker.sv
// checker for the tree assignment block: tracks the tree state, predicts each result and compares
`timescale 1ns / 1ps
module btmca_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     cmd,
  input  logic [btmca_pkg::NODE_W-1:0]   node,
  input  logic [btmca_pkg::CAP_W-1:0]    capacity,
  input  logic                           done,
  input  logic [btmca_pkg::STEP_W-1:0]   step_cost,
  input  logic [btmca_pkg::TOTAL_W-1:0]  total_cost,
  input  logic [btmca_pkg::NODE_W-1:0]   served_node,
  input  logic                           no_capacity,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btmca_pkg::PADDR_W-1:0]  paddr,
  input  logic [btmca_pkg::DATA_W-1:0]   pwdata,
  input  logic                           pready,
  output int                             errors,
  output int                             outstanding,
  output int                             checked
);

  localparam int FLOW_HI = (1 << (btmca_pkg::FLOW_W - 1)) - 1;
  localparam int FLOW_LO = -(1 << (btmca_pkg::FLOW_W - 1));

  typedef struct {
    logic [btmca_pkg::STEP_W-1:0]  step;
    logic [btmca_pkg::TOTAL_W-1:0] total;
    logic [btmca_pkg::NODE_W-1:0]  served;
    logic                          flag;
  } assignment_t;

  assignment_t expected_assignments[$];

  logic [btmca_pkg::CAP_W-1:0]         cap_left     [0:btmca_pkg::MAX_NODES];
  logic signed [btmca_pkg::FLOW_W-1:0] flow_on_edge [0:btmca_pkg::MAX_NODES];
  logic signed [btmca_pkg::COST_W-1:0] best_cost    [0:btmca_pkg::MAX_NODES];
  logic [btmca_pkg::NODE_W-1:0]        best_node    [0:btmca_pkg::MAX_NODES];
  logic [btmca_pkg::TOTAL_W-1:0]       cost_total;
  logic [btmca_pkg::NODE_W-1:0]        nodes_used;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // cheapest capacity reachable inside the subtree of node i
  function automatic void recompute_minimum(input int i);
    bit have;
    int best;
    int who;
    int j;
    int c;
    if (i < 1 || i > nodes_used) return;
    have = cap_left[i] != 0;
    best = 0;
    who  = have ? i : 0;
    for (int k = 0; k < 2; k++) begin
      j = 2 * i + k;
      if (j <= nodes_used) begin
        if (best_node[j] != 0) begin
          c = best_cost[j] + ((flow_on_edge[j] > 0) ? -1 : 1);
          if (!have || best > c) begin
            have = 1'b1;
            best = c;
            who  = best_node[j];
          end
        end
      end
    end
    if (best > 127) best = 127;
    if (best < -128) best = -128;
    best_cost[i] = have ? btmca_pkg::COST_W'(best) : '0;
    best_node[i] = have ? btmca_pkg::NODE_W'(who) : '0;
  endfunction

  function automatic void bump_flow(input int i, input int d);
    int v;
    v = flow_on_edge[i] + d;
    if (v > FLOW_HI) v = FLOW_HI;
    if (v < FLOW_LO) v = FLOW_LO;
    flow_on_edge[i] = btmca_pkg::FLOW_W'(v);
  endfunction

  function automatic assignment_t predict_assignment(
      input logic [1:0] c,
      input logic [btmca_pkg::NODE_W-1:0] n,
      input logic [btmca_pkg::CAP_W-1:0] v);
    assignment_t r;
    int up;
    int best;
    int meet;
    int q;
    int cc;
    longint sum;
    r.step   = '0;
    r.served = '0;
    r.flag   = 1'b0;
    case (c)
      btmca_pkg::CMD_LOAD: begin
        if (n >= 1 && n <= btmca_pkg::MAX_NODES) cap_left[n] = v;
      end
      btmca_pkg::CMD_BUILD: begin
        for (int i = nodes_used; i > 0; i--) recompute_minimum(i);
      end
      btmca_pkg::CMD_SERVE: begin
        if (n < 1 || n > nodes_used) begin
          r.flag = 1'b1;
        end else begin
          up   = 0;
          best = 0;
          meet = 0;
          // search the root path for the cheapest turning point
          for (int i = n; i > 0; i = i >> 1) begin
            if (best_node[i] != 0) begin
              cc = up + best_cost[i];
              if (meet == 0 || best > cc) begin
                best = cc;
                meet = i;
              end
            end
            if (i > 1) up += (flow_on_edge[i] < 0) ? -1 : 1;
          end
          if (meet == 0) begin
            r.flag = 1'b1;
          end else begin
            q = best_node[meet];
            if (q > btmca_pkg::MAX_NODES) q = 0;
            if (q != 0 && cap_left[q] != 0) cap_left[q] = cap_left[q] - 1'b1;
            for (int i = n; i > meet; i = i >> 1) bump_flow(i, 1);
            for (int i = q; i > meet; i = i >> 1) bump_flow(i, -1);
            for (int i = n; i > 0; i = i >> 1) recompute_minimum(i);
            for (int i = q; i > 0; i = i >> 1) recompute_minimum(i);
            if (best < 0) best = 0;
            if (best > 63) best = 63;
            r.step = btmca_pkg::STEP_W'(best);
            sum = longint'(cost_total) + best;
            cost_total = (sum > 64'hFFFF_FFFF) ? '1 : btmca_pkg::TOTAL_W'(sum);
            r.served = btmca_pkg::NODE_W'(q);
          end
        end
      end
      default: ;
    endcase
    r.total = cost_total;
    return r;
  endfunction

  always @(posedge clk) begin
    assignment_t want;
    int value;
    if (rst) begin
      for (int i = 0; i <= btmca_pkg::MAX_NODES; i++) begin
        cap_left[i]     = '0;
        flow_on_edge[i] = '0;
        best_cost[i]    = '0;
        best_node[i]    = '0;
      end
      cost_total = '0;
      nodes_used = btmca_pkg::NODE_W'(1);
      expected_assignments.delete();
    end else begin
      // result first, so a transfer in the same cycle lines up behind it
      if (done === 1'b1) begin
        checked++;
        if (expected_assignments.size() == 0) begin
          $display("%0t: result with nothing expected", $realtime);
          errors++;
        end else begin
          want = expected_assignments.pop_front();
          if (step_cost !== want.step)
            report_mismatch("step_cost", 32'(step_cost), 32'(want.step));
          if (total_cost !== want.total) report_mismatch("total_cost", total_cost, want.total);
          if (served_node !== want.served)
            report_mismatch("served_node", 32'(served_node), 32'(want.served));
          if (no_capacity !== want.flag)
            report_mismatch("no_capacity", 32'(no_capacity), 32'(want.flag));
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == btmca_pkg::REG_NODE_COUNT) begin
        value = pwdata & 32'h7FF;
        if (value < 1) value = 1;
        if (value > btmca_pkg::MAX_NODES) value = btmca_pkg::MAX_NODES;
        nodes_used = btmca_pkg::NODE_W'(value);
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_assignments.push_back(predict_assignment(cmd, node, capacity));
    end
    outstanding = expected_assignments.size();
  end

endmodule

>>> tb/binary_tree_min_cost_assignment_tb.sv
// testbench top: drives commands and node count writes into the tree assignment block
`timescale 1ns / 1ps
module binary_tree_min_cost_assignment_tb;

  localparam logic [1:0]                    CMD_UNUSED      = 2'd3;
  localparam logic [btmca_pkg::PADDR_W-1:0] NODE_COUNT_ADDR = '0;
  localparam int                            RANDOM_ITEMS    = 1750;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [1:0]                    cmd;
  logic [btmca_pkg::NODE_W-1:0]  node;
  logic [btmca_pkg::CAP_W-1:0]   capacity;
  logic                          done;
  logic [btmca_pkg::STEP_W-1:0]  step_cost;
  logic [btmca_pkg::TOTAL_W-1:0] total_cost;
  logic [btmca_pkg::NODE_W-1:0]  served_node;
  logic                          no_capacity;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [btmca_pkg::PADDR_W-1:0] paddr;
  logic [btmca_pkg::DATA_W-1:0]  pwdata;
  logic [btmca_pkg::DATA_W-1:0]  prdata;
  logic                          pready;
  int                            errors;
  int                            outstanding;
  int                            checked;

  int                            items_sent;
  int                            tree_sizes;
  int                            nodes_in_use;
  bit                            gaps_on;

  binary_tree_min_cost_assignment u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .node       (node),
    .capacity   (capacity),
    .done       (done),
    .step_cost  (step_cost),
    .total_cost (total_cost),
    .served_node(served_node),
    .no_capacity(no_capacity),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  btmca_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .node       (node),
    .capacity   (capacity),
    .done       (done),
    .step_cost  (step_cost),
    .total_cost (total_cost),
    .served_node(served_node),
    .no_capacity(no_capacity),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .errors     (errors),
    .outstanding(outstanding),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("run timed out");
    $display("Simulation FAILED");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic issue(input logic [1:0] c, input int n, input int v);
    bit taken;
    cmd      = c;
    node     = btmca_pkg::NODE_W'(n);
    capacity = btmca_pkg::CAP_W'(v);
    start    = 1'b1;
    taken    = 1'b0;
    while (!taken) begin
      taken = (busy === 1'b0);
      @(negedge clk);
    end
    items_sent++;
  endtask

  task automatic idle_gap();
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 40) n = 0;
    else if (roll < 85) n = $urandom_range(1, 3);
    else if (roll < 97) n = $urandom_range(4, 20);
    else n = $urandom_range(30, 200);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_node_count(input int value, input bit junk_high);
    bit ok;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = NODE_COUNT_ADDR;
    pwdata  = btmca_pkg::DATA_W'(value & 32'h7FF);
    if (junk_high)
      pwdata[btmca_pkg::DATA_W-1:btmca_pkg::NODE_W] =
        (btmca_pkg::DATA_W - btmca_pkg::NODE_W)'($urandom());
    @(negedge clk);
    penable = 1'b1;
    ok = 1'b0;
    while (!ok) begin
      ok = (pready === 1'b1);
      @(negedge clk);
    end
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    nodes_in_use = value & 32'h7FF;
    if (nodes_in_use < 1) nodes_in_use = 1;
    if (nodes_in_use > btmca_pkg::MAX_NODES) nodes_in_use = btmca_pkg::MAX_NODES;
    tree_sizes++;
  endtask

  function automatic int pick_capacity();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 3);
    if (roll < 90) return $urandom_range(0, 65535);
    return (roll < 95) ? 65535 : 0;
  endfunction

  initial begin : stimulus
    int roll;
    int loads;
    int body;
    int raw;
    int w;
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = btmca_pkg::CMD_LOAD;
    node     = '0;
    capacity = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    items_sent   = 0;
    tree_sizes   = 0;
    nodes_in_use = 1;
    gaps_on      = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // single node tree from reset: empty, ignored items, bad origins, full capacity
    issue(btmca_pkg::CMD_LOAD, 1, 0);
    issue(CMD_UNUSED, 2047, 65535);
    issue(btmca_pkg::CMD_BUILD, 0, 0);
    issue(btmca_pkg::CMD_SERVE, 1, 0);
    issue(btmca_pkg::CMD_SERVE, 0, 0);
    issue(btmca_pkg::CMD_SERVE, 2, 0);
    issue(btmca_pkg::CMD_LOAD, 0, 5);
    issue(btmca_pkg::CMD_LOAD, 2047, 7);
    issue(btmca_pkg::CMD_LOAD, 1, 65535);
    issue(btmca_pkg::CMD_BUILD, 0, 0);
    issue(btmca_pkg::CMD_SERVE, 1, 0);
    wait_idle();

    // seven nodes: local serve, serve through the root, then run dry
    write_node_count(7, 1'b0);
    issue(btmca_pkg::CMD_LOAD, 1, 0);
    issue(btmca_pkg::CMD_LOAD, 4, 1);
    issue(btmca_pkg::CMD_LOAD, 7, 2);
    issue(btmca_pkg::CMD_BUILD, 0, 0);
    issue(btmca_pkg::CMD_SERVE, 4, 0);
    issue(btmca_pkg::CMD_SERVE, 4, 0);
    issue(btmca_pkg::CMD_SERVE, 5, 0);
    issue(btmca_pkg::CMD_SERVE, 6, 0);
    issue(btmca_pkg::CMD_SERVE, 1024, 0);
    wait_idle();

    // zero count acts as one node
    write_node_count(0, 1'b0);
    issue(btmca_pkg::CMD_SERVE, 2, 0);
    issue(btmca_pkg::CMD_LOAD, 1, 3);
    issue(btmca_pkg::CMD_BUILD, 0, 0);
    issue(btmca_pkg::CMD_SERVE, 1, 0);
    wait_idle();

    // oversized count clamps to the full tree
    write_node_count(2047, 1'b1);
    issue(btmca_pkg::CMD_LOAD, 1024, 1);
    issue(btmca_pkg::CMD_LOAD, 513, 65535);
    issue(btmca_pkg::CMD_BUILD, 0, 0);
    issue(btmca_pkg::CMD_SERVE, 1024, 0);
    issue(btmca_pkg::CMD_SERVE, 1024, 0);
    issue(btmca_pkg::CMD_SERVE, 700, 0);
    wait_idle();

    raw = items_sent + RANDOM_ITEMS;
    while (items_sent < raw) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) w = $urandom_range(1, 63);
      else if (roll < 80) w = $urandom_range(64, 1023);
      else if (roll < 92) w = 1024;
      else if (roll < 96) w = 0;
      else w = $urandom_range(1025, 2047);
      write_node_count(w, $urandom_range(0, 1));
      gaps_on = ($urandom_range(0, 99) < 80);

      // every phase starts well formed: loads, then a build before any request
      loads = $urandom_range(1, (nodes_in_use < 32) ? nodes_in_use + 2 : 40);
      repeat (loads) begin
        issue(btmca_pkg::CMD_LOAD, $urandom_range(1, nodes_in_use), pick_capacity());
        idle_gap();
      end
      issue(btmca_pkg::CMD_BUILD, $urandom_range(0, 2047), $urandom_range(0, 65535));
      idle_gap();

      body = $urandom_range(60, 200);
      repeat (body) begin
        roll = $urandom_range(0, 99);
        if (roll < 58)
          issue(btmca_pkg::CMD_SERVE, $urandom_range(1, nodes_in_use),
                $urandom_range(0, 65535));
        else if (roll < 78)
          issue(btmca_pkg::CMD_LOAD, $urandom_range(1, nodes_in_use), pick_capacity());
        else if (roll < 83)
          issue(btmca_pkg::CMD_BUILD, $urandom_range(0, 2047), $urandom_range(0, 65535));
        else if (roll < 89)
          issue(btmca_pkg::CMD_SERVE, ($urandom_range(0, 3) == 0) ? 0 :
                $urandom_range(nodes_in_use + 1, 2047), $urandom_range(0, 65535));
        else if (roll < 94)
          issue(CMD_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 65535));
        else
          issue(btmca_pkg::CMD_LOAD, $urandom_range(0, 2047), pick_capacity());
        idle_gap();
      end
      wait_idle();
    end

    start = 1'b0;
    w = 0;
    while (outstanding != 0 && w < 20000) begin
      @(negedge clk);
      w++;
    end
    if (outstanding != 0) begin
      $display("%0d results never arrived", outstanding);
      $display("Simulation FAILED");
      $finish;
    end else begin
      repeat (200) @(negedge clk);
      $display("covered %0d commands over %0d node count settings, %0d results compared",
               items_sent, tree_sizes, checked);
      $display("mismatches counted: %0d", errors);
      if (errors == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
      $finish;
    end
  end

endmodule
